>>> rtl/core/kot_pkg.sv
// shared constants, types and helpers of the k-mer occurrence tracker
`timescale 1ns / 1ps
`default_nettype none

package kot_pkg;

  // sizes
  localparam int unsigned MAX_K     = 8;
  localparam int unsigned CODE_W    = 2 * MAX_K;
  localparam int unsigned K_W       = 4;
  localparam int unsigned RUN_W     = 4;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned TBL_DEPTH = 1 << CODE_W;

  // register reset value
  localparam logic [K_W-1:0] KMER_LEN_RST = K_W'(MAX_K);

  // ascii symbols of the four bases
  localparam logic [CHAR_W-1:0] CHR_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CHR_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHR_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CHR_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CHR_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CHR_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CHR_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CHR_T_LO = 8'h74;

  // 2-bit base codes
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // decoded input symbol
  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } base_t;

  // k-mer produced by the front end for the accepted beat
  typedef struct packed {
    logic  hit;
    code_t code;
    pos_t  start;
  } kmer_item_t;

  // one table entry
  typedef struct packed {
    cnt_t count;
    pos_t last_start;
  } entry_t;

  // map an ascii byte onto a base code
  function automatic base_t base_decode(logic [CHAR_W-1:0] c);
    base_t r;
    r.valid = 1'b1;
    r.code  = BASE_A;
    case (c) inside
      CHR_A_UP, CHR_A_LO: r.code = BASE_A;
      CHR_C_UP, CHR_C_LO: r.code = BASE_C;
      CHR_G_UP, CHR_G_LO: r.code = BASE_G;
      CHR_T_UP, CHR_T_LO: r.code = BASE_T;
      default:            r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/kot_kmer_front.sv
// front end: base decode, run length, packed k-mer shift line and stream position
`timescale 1ns / 1ps
`default_nettype none

module kot_kmer_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [kot_pkg::CHAR_W-1:0] base_char_i,
  input  wire logic [kot_pkg::K_W-1:0]    kmer_len_i,
  output kot_pkg::kmer_item_t            item_o
);
  import kot_pkg::*;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
  localparam pos_t             POS_MAX = {POS_W{1'b1}};

  code_t            shift_q, shift_d;
  logic [RUN_W-1:0] run_q, run_d;
  pos_t             pos_q, pos_d;

  base_t            base;
  logic [K_W-1:0]   eff_k;
  logic [K_W:0]     code_bits;
  code_t            code_mask;

  // effective k: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (kmer_len_i == '0) begin
      eff_k = K_W'(1);
    end else if (kmer_len_i > K_W'(MAX_K)) begin
      eff_k = K_W'(MAX_K);
    end else begin
      eff_k = kmer_len_i;
    end
    code_bits = {eff_k, 1'b0};
  end

  // mask keeping the low 2k bits of the shift line
  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      code_mask[i] = (i < int'(code_bits));
    end
  end

  // next state of run, shift line and position
  always_comb begin
    base    = base_decode(base_char_i);
    shift_d = shift_q;
    run_d   = run_q;
    pos_d   = pos_q;
    if (accept_i) begin
      if (pos_q != POS_MAX) begin
        pos_d = pos_q + POS_W'(1);
      end
      if (base.valid) begin
        shift_d = {shift_q[CODE_W-3:0], base.code};
        if (run_q != RUN_MAX) begin
          run_d = run_q + RUN_W'(1);
        end
      end else begin
        run_d = '0;
      end
    end
  end

  // k-mer of the current beat
  always_comb begin
    item_o.hit   = accept_i && base.valid && (run_d >= RUN_W'(eff_k));
    item_o.code  = shift_d & code_mask;
    item_o.start = pos_q - POS_W'(eff_k - K_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      run_q   <= '0;
      pos_q   <= '0;
    end else begin
      shift_q <= shift_d;
      run_q   <= run_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kmer_occurrence_tracker.sv
// top level: k-mer occurrence table with read-modify-write pipeline
`timescale 1ns / 1ps
`default_nettype none

// Streaming k-mer occurrence tracker. One ASCII base is taken per beat on
// the input channel, one per clock cycle when neither side stalls. Each
// k-mer result passes through the synchronous read of the 65536-entry
// occurrence table and then the count and gap update into the output
// register; the table port is read once and written once per cycle, and a
// hit on the entry updated the cycle before is forwarded. After reset the
// block sweeps the table to zero, one entry a cycle, holding the input
// stalled until the sweep is done; kmer_len may be written during that
// sweep. Bytes other than A, C, G, T (either case) emit nothing and restart
// the run of bases, but still advance the stream position.
module kmer_occurrence_tracker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [kot_pkg::K_W-1:0]    cfg_data_i,
  // base beats
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [kot_pkg::CHAR_W-1:0] base_char_i,
  // result beats
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [kot_pkg::CODE_W-1:0]      kmer_code_o,
  output logic [kot_pkg::POS_W-1:0]       start_position_o,
  output logic                            seen_before_o,
  output logic [kot_pkg::POS_W-1:0]       gap_distance_o,
  output logic [kot_pkg::CNT_W-1:0]       occurrence_count_o
);
  import kot_pkg::*;

  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

  // configuration register
  logic [K_W-1:0] kmer_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q <= KMER_LEN_RST;
    end else if (cfg_we_i) begin
      kmer_len_q <= cfg_data_i;
    end
  end

  // clearing sweep after reset
  logic  clr_q, clr_d;
  code_t clr_addr_q, clr_addr_d;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + CODE_W'(1);
      if (clr_addr_q == {CODE_W{1'b1}}) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // handshake and pipeline control
  logic       s1_vld_q, s1_vld_d;
  logic       out_vld_q, out_vld_d;
  logic       out_free, s1_go, in_accept;
  kmer_item_t item;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_go      = s1_vld_q && out_free;
  assign in_stall_o = clr_q || (s1_vld_q && !out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  kot_kmer_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .base_char_i (base_char_i),
    .kmer_len_i  (kmer_len_q),
    .item_o      (item)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (item.hit) begin
      s1_vld_d = 1'b1;
    end else if (s1_go) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = s1_go || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // stage 1 payload
  code_t s1_code_q;
  pos_t  s1_start_q;

  always_ff @(posedge clk_i) begin
    if (item.hit) begin
      s1_code_q  <= item.code;
      s1_start_q <= item.start;
    end
  end

  // occurrence table: count and last start per k-mer
  entry_t mem_q [TBL_DEPTH];
  entry_t rd_q;
  entry_t wr_data;
  logic   mem_we;
  code_t  mem_waddr;
  entry_t mem_wdata;

  always_comb begin
    mem_we    = clr_q || s1_go;
    mem_waddr = clr_q ? clr_addr_q : s1_code_q;
    mem_wdata = clr_q ? entry_t'('0) : wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (item.hit) begin
      rd_q <= mem_q[item.code];
    end
  end

  // forwarding of the last update
  logic   fwd_vld_q;
  code_t  fwd_addr_q;
  entry_t fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (s1_go) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      fwd_addr_q <= s1_code_q;
      fwd_data_q <= wr_data;
    end
  end

  // count and gap update
  entry_t ent;
  logic   seen;
  pos_t   gap;

  always_comb begin
    ent = (fwd_vld_q && (fwd_addr_q == s1_code_q)) ? fwd_data_q : rd_q;
    seen = (ent.count != '0);
    gap  = seen ? (s1_start_q - ent.last_start) : '0;
    wr_data.count      = (ent.count == CNT_MAX) ? ent.count : ent.count + CNT_W'(1);
    wr_data.last_start = s1_start_q;
  end

  // output register
  code_t out_code_q;
  pos_t  out_start_q;
  logic  out_seen_q;
  pos_t  out_gap_q;
  cnt_t  out_cnt_q;

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_code_q  <= s1_code_q;
      out_start_q <= s1_start_q;
      out_seen_q  <= seen;
      out_gap_q   <= gap;
      out_cnt_q   <= wr_data.count;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign kmer_code_o        = out_code_q;
  assign start_position_o   = out_start_q;
  assign seen_before_o      = out_seen_q;
  assign gap_distance_o     = out_gap_q;
  assign occurrence_count_o = out_cnt_q;

  // checks
  a_no_work_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (!s1_vld_q && !out_vld_q))
    else $error("pipeline busy during table clear");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_cnt_q != '0))
    else $error("result with zero occurrence count");

  a_first_occurrence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_seen_q) |-> ((out_gap_q == '0) && (out_cnt_q == CNT_W'(1))))
    else $error("first occurrence with gap or count above one");

  a_repeat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_seen_q) |-> (out_cnt_q > CNT_W'(1)))
    else $error("repeat occurrence with count of one");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !out_vld_q) |=> out_vld_q)
    else $error("stage 1 item did not reach the output register");

endmodule

`default_nettype wire
